/* rtl/scd_pkg.sv */
// Shared constants and types for the streaming chunk deframer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package scd_pkg;

    localparam logic [15:0] TYPE_HEADER       = 16'h4824;
    localparam logic [15:0] TYPE_DATA         = 16'h4424;
    localparam logic [15:0] SIZE_BIAS         = 16'd8;
    localparam logic [3:0]  HDR_LAST_IDX      = 4'd11;
    localparam logic [15:0] FRAME_LEN_RESET   = 16'd4096;
    localparam int          QUEUE_DEPTH       = 4;

    // One pending result, as the parser hands it to the output side.
    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data;
        logic        is_header;
        logic        last;
        logic        pad_en;
        logic [15:0] len;
        logic        error;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

endpackage

`default_nettype wire

/* rtl/scd_front.sv */
// Chunk header parser and classifier for the deframer.
// Depends on scd_pkg; pushes one operation per result into the queue.
`default_nettype none

module scd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic [15:0]   i_frame_len,
    input  wire logic          i_q_ready,
    output scd_pkg::t_push     o_push
);
    import scd_pkg::*;

    typedef enum logic [1:0] {
        ACT_DISCARD = 2'd0,
        ACT_HEADER  = 2'd1,
        ACT_DATA    = 2'd2
    } t_action;

    logic [3:0]  r_hdr_idx, n_hdr_idx;
    logic [15:0] r_type, n_type;
    logic [15:0] r_size, n_size;
    logic [15:0] r_left, n_left;
    t_action     r_action, n_action;
    logic        r_seen, n_seen;
    logic        r_halted, n_halted;
    logic        w_accept;
    logic [15:0] w_len;
    t_push       w_push;

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && i_q_ready;
    assign w_len      = (r_size >= SIZE_BIAS) ? (r_size - SIZE_BIAS) : 16'd0;

    always_comb begin
        n_hdr_idx = r_hdr_idx;
        n_type    = r_type;
        n_size    = r_size;
        n_left    = r_left;
        n_action  = r_action;
        n_seen    = r_seen;
        n_halted  = r_halted;
        w_push    = '0;
        w_push.op.data = i_in_byte;
        w_push.op.len  = w_len;
        if (w_accept && !r_halted) begin
            if (r_left != 16'd0) begin
                n_left = r_left - 16'd1;
                w_push.op.has_byte  = 1'b1;
                w_push.op.last      = (r_left == 16'd1);
                case (r_action)
                    ACT_HEADER: begin
                        w_push.valid        = 1'b1;
                        w_push.op.is_header = 1'b1;
                    end
                    ACT_DATA: begin
                        w_push.valid     = 1'b1;
                        w_push.op.pad_en = (r_left == 16'd1);
                    end
                    default: begin
                        w_push.valid = 1'b0;
                    end
                endcase
            end else begin
                case (r_hdr_idx)
                    4'd0: n_type = {8'h00, i_in_byte};
                    4'd1: n_type = {i_in_byte, r_type[7:0]};
                    4'd2: n_size = {8'h00, i_in_byte};
                    4'd3: n_size = {i_in_byte, r_size[7:0]};
                    default: n_type = r_type;
                endcase
                n_hdr_idx = r_hdr_idx + 4'd1;
                if (r_hdr_idx == HDR_LAST_IDX) begin
                    n_hdr_idx = 4'd0;
                    n_action  = ACT_DISCARD;
                    n_left    = w_len;
                    if (r_type == TYPE_HEADER && !r_seen) begin
                        n_seen   = 1'b1;
                        n_action = ACT_HEADER;
                    end else if (r_type == TYPE_DATA && r_seen) begin
                        if (w_len > i_frame_len) begin
                            n_halted        = 1'b1;
                            n_left          = 16'd0;
                            w_push.valid    = 1'b1;
                            w_push.op.data  = 8'h00;
                            w_push.op.len   = 16'd0;
                            w_push.op.error = 1'b1;
                        end else begin
                            n_action = ACT_DATA;
                            if (w_len == 16'd0) begin
                                w_push.valid     = 1'b1;
                                w_push.op.data   = 8'h00;
                                w_push.op.last   = 1'b1;
                                w_push.op.pad_en = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    assign o_push = w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= 4'd0;
            r_type    <= 16'd0;
            r_size    <= 16'd0;
            r_left    <= 16'd0;
            r_action  <= ACT_DISCARD;
            r_seen    <= 1'b0;
            r_halted  <= 1'b0;
        end else begin
            r_hdr_idx <= n_hdr_idx;
            r_type    <= n_type;
            r_size    <= n_size;
            r_left    <= n_left;
            r_action  <= n_action;
            r_seen    <= n_seen;
            r_halted  <= n_halted;
        end
    end

endmodule

`default_nettype wire

/* rtl/scd_queue.sv */
// Small register queue of pending operations between parser and output side.
// Depends on scd_pkg for the operation type; depth must be a power of two.
`default_nettype none

module scd_queue #(
    parameter int P_DEPTH = scd_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  scd_pkg::t_push  i_push,
    output logic            o_ready,
    output logic            o_valid,
    output scd_pkg::t_op    o_op,
    input  wire logic       i_pop
);
    import scd_pkg::*;

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_op             r_mem [P_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_wr;
    logic            w_rd;

    assign o_ready = (r_count != CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign w_wr    = i_push.valid && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count + CW'(w_wr) - CW'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/scd_back.sv */
// Output side of the deframer: works out padding and holds the result beat.
// Depends on scd_pkg; drains operations from scd_queue.
`default_nettype none

module scd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  scd_pkg::t_op       i_op,
    output logic               o_pop,
    input  wire logic [15:0]   i_frame_len,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic               o_has_byte,
    output logic [7:0]         o_out_byte,
    output logic               o_is_header,
    output logic               o_last_of_chunk,
    output logic [15:0]        o_pad_zeros,
    output logic               o_error
);
    import scd_pkg::*;

    logic        r_valid;
    logic        r_has_byte;
    logic [7:0]  r_byte;
    logic        r_is_header;
    logic        r_last;
    logic [15:0] r_pad;
    logic        r_error;
    logic [15:0] w_pad;

    assign o_pop = i_q_valid && (!r_valid || i_out_ready);
    assign w_pad = (i_op.pad_en && (i_frame_len > i_op.len)) ?
                   (i_frame_len - i_op.len) : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_has_byte  <= i_op.has_byte;
            r_byte      <= i_op.data;
            r_is_header <= i_op.is_header;
            r_last      <= i_op.last;
            r_pad       <= w_pad;
            r_error     <= i_op.error;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_has_byte      = r_has_byte;
    assign o_out_byte      = r_byte;
    assign o_is_header     = r_is_header;
    assign o_last_of_chunk = r_last;
    assign o_pad_zeros     = r_pad;
    assign o_error         = r_error;

endmodule

`default_nettype wire

/* rtl/streaming_chunk_deframer.sv */
// Top level of the streaming chunk deframer: packet size register and the
// parser, queue and output stages. Depends on scd_pkg, scd_front, scd_queue
// and scd_back.
//
//   Channel  Handshake                    Payload
//   input    i_in_valid / o_in_ready      i_in_byte
//   output   o_out_valid / i_out_ready    o_has_byte, o_out_byte, o_is_header,
//                                         o_last_of_chunk, o_pad_zeros, o_error
//   config   i_cfg_wr_en                  i_cfg_wr_data
//
// One input beat is taken per cycle while the queue has room; a result is written
// from the parser into the queue and is then registered in the output register.
// Reset clears the parser, the queue and the output register and sets the
// packet size to 4096. An output stall fills the queue; input is refused only
// when the queue is full.
`default_nettype none

module streaming_chunk_deframer #(
    parameter int P_QUEUE_DEPTH = scd_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [15:0]   i_cfg_wr_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_in_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic               o_has_byte,
    output logic [7:0]         o_out_byte,
    output logic               o_is_header,
    output logic               o_last_of_chunk,
    output logic [15:0]        o_pad_zeros,
    output logic               o_error
);
    import scd_pkg::*;

    logic [15:0] r_frame_len;
    t_push       w_push;
    logic        w_q_ready;
    logic        w_q_valid;
    t_op         w_q_op;
    logic        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_frame_len <= i_cfg_wr_data;
        end
    end

    scd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_frame_len   (r_frame_len),
        .i_q_ready     (w_q_ready),
        .o_push        (w_push)
    );

    scd_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_op    (w_q_op),
        .i_pop   (w_pop)
    );

    scd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_op            (w_q_op),
        .o_pop           (w_pop),
        .i_frame_len     (r_frame_len),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_has_byte      (o_has_byte),
        .o_out_byte      (o_out_byte),
        .o_is_header     (o_is_header),
        .o_last_of_chunk (o_last_of_chunk),
        .o_pad_zeros     (o_pad_zeros),
        .o_error         (o_error)
    );

endmodule

`default_nettype wire

/* verif/streaming_chunk_deframer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for streaming_chunk_deframer, built around a chunk parsing scoreboard.
// It drives framed byte streams with random gaps and stalls and checks every output beat.
// Depends on scd_pkg and the streaming_chunk_deframer RTL.

module streaming_chunk_deframer_tb;

    import scd_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_BYTES  = 250;
    localparam int          QUIET_PHASE   = 0;
    localparam int          QUIET_CHUNKS  = 8;
    localparam logic [7:0]  CHUNK_MARK    = 8'h24;
    localparam logic [7:0]  LETTER_FIRST  = 8'h41;
    localparam logic [7:0]  LETTER_LAST   = 8'h5A;
    localparam logic [15:0] TYPE_OTHER    = 16'h5824;
    localparam logic [15:0] TYPE_SWAPPED  = 16'h2448;
    localparam logic [15:0] SIZE_OVERSIZE = 16'hFFFF;

    typedef enum logic [1:0] {ACT_DISCARD, ACT_HEADER, ACT_DATA} t_chunk_action;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data;
        logic        is_header;
        logic        last;
        logic [15:0] pad;
        logic        error;
    } t_deframe_beat;

    class deframe_scoreboard;
        logic [15:0]   frame_len;
        logic [3:0]    header_count;
        logic [15:0]   chunk_type;
        logic [15:0]   chunk_size;
        logic [15:0]   payload_left;
        t_chunk_action action;
        bit            header_seen;
        bit            halted;
        t_deframe_beat due_beats[$];
        int            mismatches;

        function new();
            frame_len    = FRAME_LEN_RESET;
            header_count = 4'd0;
            chunk_type   = 16'd0;
            chunk_size   = 16'd0;
            payload_left = 16'd0;
            action       = ACT_DISCARD;
            header_seen  = 1'b0;
            halted       = 1'b0;
            mismatches   = 0;
        endfunction

        function t_deframe_beat beat_of(logic has, logic [7:0] data, logic hdr, logic last,
                                        logic [15:0] pad, logic err);
            t_deframe_beat beat;
            beat.has_byte  = has;
            beat.data      = data;
            beat.is_header = hdr;
            beat.last      = last;
            beat.pad       = pad;
            beat.error     = err;
            return beat;
        endfunction

        function int pending();
            return due_beats.size();
        endfunction

        function void note_byte(logic [7:0] value);
            logic [15:0] len;
            logic [15:0] pad;
            len = 16'd0;
            pad = 16'd0;
            if (halted) return;
            if (payload_left != 16'd0) begin
                payload_left = payload_left - 16'd1;
                if (action == ACT_HEADER) begin
                    due_beats.push_back(beat_of(1'b1, value, 1'b1, payload_left == 16'd0,
                                                16'd0, 1'b0));
                end else if (action == ACT_DATA) begin
                    if (payload_left == 16'd0) begin
                        len = chunk_size - SIZE_BIAS;
                        pad = (frame_len > len) ? frame_len - len : 16'd0;
                    end
                    due_beats.push_back(beat_of(1'b1, value, 1'b0, payload_left == 16'd0,
                                                pad, 1'b0));
                end
                return;
            end
            case (header_count)
                4'd0: chunk_type = {8'h00, value};
                4'd1: chunk_type[15:8] = value;
                4'd2: chunk_size = {8'h00, value};
                4'd3: chunk_size[15:8] = value;
                default: ;
            endcase
            if (header_count != HDR_LAST_IDX) begin
                header_count = header_count + 4'd1;
                return;
            end
            header_count = 4'd0;
            len = (chunk_size >= SIZE_BIAS) ? chunk_size - SIZE_BIAS : 16'd0;
            action = ACT_DISCARD;
            if (chunk_type == TYPE_HEADER && !header_seen) begin
                header_seen = 1'b1;
                action = ACT_HEADER;
            end else if (chunk_type == TYPE_DATA && header_seen) begin
                if (len > frame_len) begin
                    halted = 1'b1;
                    due_beats.push_back(beat_of(1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 1'b1));
                    return;
                end
                action = ACT_DATA;
                if (len == 16'd0) begin
                    due_beats.push_back(beat_of(1'b0, 8'd0, 1'b0, 1'b1, frame_len, 1'b0));
                end
            end
            payload_left = len;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
            end
        endtask

        task check_beat(t_deframe_beat got);
            t_deframe_beat want;
            if (due_beats.size() == 0) begin
                report_mismatch($sformatf("output beat %h with nothing expected", got));
                return;
            end
            want = due_beats.pop_front();
            check_field("has_byte", 16'(got.has_byte), 16'(want.has_byte));
            check_field("out_byte", 16'(got.data), 16'(want.data));
            check_field("is_header", 16'(got.is_header), 16'(want.is_header));
            check_field("last_of_chunk", 16'(got.last), 16'(want.last));
            check_field("pad_zeros", got.pad, want.pad);
            check_field("error", 16'(got.error), 16'(want.error));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_has_byte;
    logic [7:0]  o_out_byte;
    logic        o_is_header;
    logic        o_last_of_chunk;
    logic [15:0] o_pad_zeros;
    logic        o_error;

    deframe_scoreboard board;
    logic [7:0]        stream_q[$];
    bit                in_gaps;
    bit                out_gaps;
    int                bytes_sent = 0;
    int                cycles = 0;

    streaming_chunk_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_has_byte      (o_has_byte),
        .o_out_byte      (o_out_byte),
        .o_is_header     (o_is_header),
        .o_last_of_chunk (o_last_of_chunk),
        .o_pad_zeros     (o_pad_zeros),
        .o_error         (o_error)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_beat(board.beat_of(o_has_byte, o_out_byte, o_is_header,
                                           o_last_of_chunk, o_pad_zeros, o_error));
        end
        i_out_ready <= !(out_gaps && $urandom_range(99) < 35);
    end

    task automatic add_header(input logic [15:0] kind, input logic [15:0] size);
        stream_q.push_back(kind[7:0]);
        stream_q.push_back(kind[15:8]);
        stream_q.push_back(size[7:0]);
        stream_q.push_back(size[15:8]);
        repeat (8) stream_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_chunk(input logic [15:0] kind, input logic [15:0] size);
        add_header(kind, size);
        if (size > SIZE_BIAS) begin
            repeat (size - SIZE_BIAS) stream_q.push_back(8'($urandom_range(255)));
        end
    endtask

    // Data chunks never exceed the current packet size, so the block only halts at the end.
    task automatic add_random_chunk();
        int          pick;
        int          cap;
        logic [7:0]  letter;
        logic [15:0] kind;
        logic [15:0] size;
        pick   = int'($urandom_range(99));
        letter = 8'($urandom_range(LETTER_LAST, LETTER_FIRST));
        cap    = ($urandom_range(19) == 0) ? 600 : 40;
        if (cap > int'(board.frame_len)) cap = int'(board.frame_len);
        if (pick < 70) begin
            kind = TYPE_DATA;
        end else if (pick < 78) begin
            kind = TYPE_HEADER;
        end else if (pick < 90) begin
            kind = {letter, CHUNK_MARK};
        end else begin
            kind = 16'($urandom_range(16'hFFFF));
        end
        if (kind != TYPE_DATA) begin
            size = 16'($urandom_range(40));
        end else if ($urandom_range(9) == 0) begin
            size = 16'($urandom_range(7));
        end else begin
            size = 16'($urandom_range(cap)) + SIZE_BIAS;
        end
        add_chunk(kind, size);
    endtask

    task automatic send_stream(input int count);
        logic [7:0] value;
        repeat (count) begin
            if (stream_q.size() == 0) break;
            value = stream_q.pop_front();
            while (in_gaps && $urandom_range(99) < 35) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_byte  <= value;
            do @(posedge i_clk); while (!o_in_ready);
            board.note_byte(value);
            bytes_sent++;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_len(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.frame_len = value;
    endtask

    initial begin
        int          phase;
        int          start;
        int          held;
        logic [15:0] pkt_size;
        board = new();
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 16'd0;
        i_in_valid    <= 1'b0;
        i_in_byte     <= 8'd0;
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Data before any header, foreign types, first and repeated header chunks,
        // empty and short data chunks under the reset packet size.
        add_chunk(TYPE_DATA, 16'd11);
        add_chunk(TYPE_OTHER, 16'd5);
        add_chunk(TYPE_SWAPPED, 16'd9);
        add_chunk(TYPE_HEADER, 16'd13);
        add_chunk(TYPE_HEADER, 16'd10);
        add_chunk(TYPE_DATA, 16'd8);
        add_chunk(TYPE_DATA, 16'd3);
        add_chunk(TYPE_DATA, 16'd14);
        send_stream(stream_q.size());
        settle();

        write_frame_len(16'hFFFF);
        add_chunk(TYPE_DATA, 16'd9);
        add_chunk(TYPE_DATA, 16'd0);
        send_stream(stream_q.size());
        settle();

        write_frame_len(16'd0);
        add_chunk(TYPE_DATA, 16'd8);
        add_chunk(TYPE_DATA, 16'd7);
        send_stream(stream_q.size());
        settle();

        // The second chunk is cut mid-payload and finished under a smaller packet size.
        write_frame_len(16'd7);
        add_chunk(TYPE_DATA, 16'd15);
        add_chunk(TYPE_DATA, 16'd14);
        send_stream(stream_q.size() - 3);
        settle();
        write_frame_len(16'd2);
        send_stream(stream_q.size());
        settle();

        phase = 0;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            in_gaps  = (phase != QUIET_PHASE);
            out_gaps = in_gaps;
            case ($urandom_range(9))
                0: pkt_size = 16'd0;
                1: pkt_size = 16'hFFFF;
                2: pkt_size = 16'($urandom_range(16'hFFFF));
                default: pkt_size = 16'($urandom_range(64, 1));
            endcase
            write_frame_len(pkt_size);
            repeat ((phase == QUIET_PHASE) ? QUIET_CHUNKS : $urandom_range(6, 2)) begin
                add_random_chunk();
            end
            if (board.frame_len >= 16'd2 && $urandom_range(2) == 0) begin
                held = int'($urandom_range((board.frame_len < 16'd30) ?
                                           board.frame_len : 16'd30, 2));
                add_chunk(TYPE_DATA, 16'(held) + SIZE_BIAS);
                send_stream(stream_q.size() - $urandom_range(held, 1));
            end else begin
                send_stream(stream_q.size());
            end
            settle();
            phase++;
        end

        // An oversize data chunk halts the block; later beats and writes give nothing.
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        write_frame_len(16'd100);
        add_header(TYPE_DATA, SIZE_OVERSIZE);
        add_chunk(TYPE_DATA, 16'd20);
        add_chunk(TYPE_HEADER, 16'd12);
        send_stream(stream_q.size());
        settle();
        write_frame_len(16'hFFFF);
        add_chunk(TYPE_DATA, 16'd9);
        send_stream(stream_q.size());
        settle();

        if (board.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/scd_pkg.sv
rtl/scd_front.sv
rtl/scd_queue.sv
rtl/scd_back.sv
rtl/streaming_chunk_deframer.sv
verif/streaming_chunk_deframer_tb.sv
